>>> design/pfxev_pkg.sv
package pfxev_pkg;

  // data path and stack sizing
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int DIV_STEPS   = DATA_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  // character codes
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_REM  = 8'h25;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_BADCH = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_REM
  } alu_op_t;

  typedef enum logic [1:0] {
    AP_IDLE,
    AP_DIV,
    AP_FIX
  } alu_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_RHS,
    S_START,
    S_BUSY,
    S_TOP_RD,
    S_TOP_CAP,
    S_REPORT
  } pfxev_state_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              divz;
    logic [DATA_W-1:0] res;
  } alu_rsp_t;

  // keep only the first error of an expression
  function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
    first_err = (cur == ST_OK) ? code : cur;
  endfunction

endpackage

>>> design/pfxev_ram.sv
module pfxev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pfxev_alu.sv
module pfxev_alu
  import pfxev_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_phase_t        phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic              is_rem_r, is_rem_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              done_r, done_nxt;
  logic              divz_r, divz_nxt;

  logic              is_divide;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign is_divide = (req.op == OP_DIV) || (req.op == OP_REM);
  assign rem_sh    = {rem_r, quo_r[DATA_W-1]};
  assign diff      = rem_sh - {1'b0, dvs_r};

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      AP_IDLE: begin
        if (req.start && is_divide && (req.rhs != '0)) begin
          phase_nxt = AP_DIV;
        end
      end
      AP_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          phase_nxt = AP_FIX;
        end
      end
      AP_FIX:  phase_nxt = AP_IDLE;
      default: phase_nxt = AP_IDLE;
    endcase
  end

  // shared arithmetic: add, sub, mul computed directly; restoring divide one bit per cycle
  always_comb begin
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    is_rem_nxt = is_rem_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    divz_nxt   = 1'b0;
    case (phase_r)
      AP_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_ADD: begin
              res_nxt  = req.lhs + req.rhs;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = req.lhs - req.rhs;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              res_nxt  = req.lhs * req.rhs;
              done_nxt = 1'b1;
            end
            default: begin
              if (req.rhs == '0) begin
                res_nxt  = '0;
                divz_nxt = 1'b1;
                done_nxt = 1'b1;
              end else begin
                quo_nxt    = req.lhs[DATA_W-1] ? -req.lhs : req.lhs;
                dvs_nxt    = req.rhs[DATA_W-1] ? -req.rhs : req.rhs;
                rem_nxt    = '0;
                cnt_nxt    = '0;
                neg_q_nxt  = req.lhs[DATA_W-1] ^ req.rhs[DATA_W-1];
                neg_r_nxt  = req.lhs[DATA_W-1];
                is_rem_nxt = (req.op == OP_REM);
              end
            end
          endcase
        end
      end
      AP_DIV: begin
        if (!diff[DATA_W]) begin
          rem_nxt = diff[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      AP_FIX: begin
        // quotient truncates toward zero, remainder takes the dividend's sign
        if (is_rem_r) begin
          res_nxt = neg_r_r ? -rem_r : rem_r;
        end else begin
          res_nxt = neg_q_r ? -quo_r : quo_r;
        end
        done_nxt = 1'b1;
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= AP_IDLE;
      done_r  <= 1'b0;
      divz_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      divz_r  <= divz_nxt;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_r_r  <= neg_r_nxt;
    is_rem_r <= is_rem_nxt;
    res_r    <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.divz = divz_r;
  assign rsp.res  = res_r;

endmodule

>>> design/prefix_expression_evaluator.sv
// Prefix expression evaluator.
// Input channel in_*: one character of the reversed prefix expression per
// request, in_tdata[7:0] = ch, in_tlast marks the final character.
// Output channel out_*: one request per expression, sent after the character
// flagged by in_tlast; out_tdata[31:0] = value (top of stack, signed),
// out_tdata[34:32] = status (0 ok, 1 underflow, 2 overflow, 3 divide by zero,
// 4 bad character).
// Per character: a digit, a bad character or an operator short of operands
// is handled in the idle state; + - * and a division by zero take one pass
// through the shared arithmetic unit, and / and % run its 32-step radix-2
// divider. Operands come from a 16-entry stack memory with one
// registered read port, read one entry per cycle.
// After the final character the top is read and the output register loaded.
// in_tready is high only while no character is in progress.
// If the receiver stalls, the result waits in the output register; the next
// expression is still taken in and processed until its own result is due.
// Reset empties the stack and clears the error; the stack memory itself is
// not cleared.
module prefix_expression_evaluator
  import pfxev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [34:32] status, [39:35] zero
);

  pfxev_state_t      state_r, state_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [2:0]        err_r, err_nxt;
  alu_op_t           op_r, op_nxt;
  logic              last_r, last_nxt;
  logic [DATA_W-1:0] lhs_r, lhs_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [2:0]        out_status_r, out_status_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              in_req;
  logic              ch_digit;
  logic              ch_oper;
  alu_op_t           ch_op;
  logic [LEVEL_W-1:0] level_m1;
  logic [LEVEL_W-1:0] level_m2;
  logic              out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign level_m1  = level_r - LEVEL_W'(1);
  assign level_m2  = level_r - LEVEL_W'(2);
  assign out_free  = !out_tvalid_r || out_tready;

  // character decode
  always_comb begin
    ch_digit = (in_tdata inside {[CH_ZERO:CH_NINE]});
    ch_oper  = 1'b1;
    case (in_tdata)
      CH_ADD:  ch_op = OP_ADD;
      CH_SUB:  ch_op = OP_SUB;
      CH_MUL:  ch_op = OP_MUL;
      CH_DIV:  ch_op = OP_DIV;
      CH_REM:  ch_op = OP_REM;
      default: begin
        ch_op   = OP_ADD;
        ch_oper = 1'b0;
      end
    endcase
  end

  // operand stack
  pfxev_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared arithmetic unit
  pfxev_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_req) begin
          if (ch_oper && (level_r >= LEVEL_W'(2))) begin
            state_nxt = S_RD_RHS;
          end else if (in_tlast) begin
            state_nxt = S_TOP_RD;
          end
        end
      end
      S_RD_RHS: state_nxt = S_START;
      S_START:  state_nxt = S_BUSY;
      S_BUSY: begin
        if (alu_rsp.done) begin
          state_nxt = last_r ? S_TOP_RD : S_IDLE;
        end
      end
      S_TOP_RD:  state_nxt = (level_r == '0) ? S_REPORT : S_TOP_CAP;
      S_TOP_CAP: state_nxt = S_REPORT;
      S_REPORT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs and data path
  always_comb begin
    level_nxt      = level_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    lhs_nxt        = lhs_r;
    top_nxt        = top_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = level_r[ADDR_W-1:0];
    ram_wdata      = DATA_W'(in_tdata - CH_ZERO);
    ram_raddr      = level_m1[ADDR_W-1:0];
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;
    alu_req.lhs    = lhs_r;
    alu_req.rhs    = ram_rdata;
    case (state_r)
      S_IDLE: begin
        if (in_req) begin
          op_nxt   = ch_op;
          last_nxt = in_tlast;
          if (ch_digit) begin
            // push, or drop on a full stack
            if (level_r >= LEVEL_W'(STACK_DEPTH)) begin
              err_nxt = first_err(err_r, ST_OVER);
            end else begin
              ram_we    = 1'b1;
              level_nxt = level_r + LEVEL_W'(1);
            end
          end else if (ch_oper) begin
            if (level_r < LEVEL_W'(2)) begin
              err_nxt = first_err(err_r, ST_UNDER);
            end
          end else begin
            err_nxt = first_err(err_r, ST_BADCH);
          end
        end
      end
      S_RD_RHS: begin
        lhs_nxt   = ram_rdata;
        ram_raddr = level_m2[ADDR_W-1:0];
      end
      S_START: begin
        alu_req.start = 1'b1;
      end
      S_BUSY: begin
        // pop two, push the result
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_waddr = level_m2[ADDR_W-1:0];
          ram_wdata = alu_rsp.res;
          level_nxt = level_m1;
          if (alu_rsp.divz) begin
            err_nxt = first_err(err_r, ST_DIVZ);
          end
        end
      end
      S_TOP_RD: begin
        if (level_r == '0) begin
          err_nxt = first_err(err_r, ST_UNDER);
          top_nxt = '0;
        end
      end
      S_TOP_CAP: begin
        top_nxt = ram_rdata;
      end
      S_REPORT: begin
        // load the output register and start a fresh expression
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_value_nxt  = top_r;
          out_status_nxt = err_r;
          level_nxt      = '0;
          err_nxt        = ST_OK;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      level_r      <= '0;
      err_r        <= ST_OK;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      level_r      <= level_nxt;
      err_r        <= err_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    lhs_r        <= lhs_nxt;
    top_r        <= top_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_status_r, out_value_r};

  // stack level never passes the depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level above depth");

  // a sent report leaves an empty stack and no error
  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPORT && out_free) |=> (level_r == '0 && err_r == ST_OK && out_tvalid_r))
    else $error("report did not clear the expression");

  // the arithmetic unit only answers while the sequencer waits for it
  a_alu_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_BUSY)
    else $error("arithmetic result outside busy state");

  // a status is always a defined code
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_status_r <= ST_BADCH)
    else $error("status out of range");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pfxev_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          RANDOM_CHARS = 400;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          LONG_HOLD_CYCLES = 400;

  // one character request and one expected report
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       drain;
  } char_req_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
  } eval_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] ch
  logic        in_tlast = 1'b0;    // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [31:0] value, [34:32] status

  char_req_t    pending_q[$];
  eval_result_t result_q[$];

  // predictor state
  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_level = 0;
  logic [2:0]  calc_err = ST_OK;

  int unsigned cyc = 0;
  int          errors = 0;
  int          total_chars = 0;
  int          accepted_chars = 0;
  int          reports_seen = 0;
  logic        drain_next = 1'b0;

  prefix_expression_evaluator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // expression predictor
  // ---------------------------------------------------------------------------
  function automatic void keep_first_error(logic [2:0] code);
    if (calc_err == ST_OK) calc_err = code;
  endfunction

  function automatic void evaluate_char(logic [7:0] c, logic last);
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    logic [31:0]  res;
    longint       a;
    longint       b;
    logic [63:0]  wide;
    eval_result_t rep;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (calc_level >= STACK_DEPTH) begin
        keep_first_error(ST_OVER);
      end else begin
        calc_stack[calc_level] = 32'(c - CH_ZERO);
        calc_level++;
      end
    end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV || c == CH_REM) begin
      if (calc_level < 2) begin
        keep_first_error(ST_UNDER);
      end else begin
        // first popped is the left operand
        lhs = calc_stack[calc_level-1];
        rhs = calc_stack[calc_level-2];
        calc_level -= 2;
        case (c)
          CH_ADD: res = lhs + rhs;
          CH_SUB: res = lhs - rhs;
          CH_MUL: res = lhs * rhs;
          default: begin
            if (rhs == 32'd0) begin
              keep_first_error(ST_DIVZ);
              res = 32'd0;
            end else begin
              // 64-bit math keeps min-int over minus one well defined
              a = longint'($signed(lhs));
              b = longint'($signed(rhs));
              wide = (c == CH_DIV) ? a / b : a % b;
              res = wide[31:0];
            end
          end
        endcase
        calc_stack[calc_level] = res;
        calc_level++;
      end
    end else begin
      keep_first_error(ST_BADCH);
    end

    // report at the end of an expression
    if (last) begin
      rep.value = 32'd0;
      if (calc_level == 0) keep_first_error(ST_UNDER);
      else rep.value = calc_stack[calc_level-1];
      rep.status = calc_err;
      result_q.push_back(rep);
      calc_level = 0;
      calc_err = ST_OK;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void add_char(logic [7:0] c);
    char_req_t r;
    r.ch = c;
    r.last = 1'b0;
    r.drain = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(r);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void end_expression();
    if (pending_q.size() != 0) pending_q[pending_q.size()-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_op();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = CH_ADD;
      1: c = CH_SUB;
      2: c = CH_MUL;
      3: c = CH_DIV;
      default: c = CH_REM;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // valid postfix stream with the odd stray character
  function automatic void add_well_formed();
    int depth;
    int len;
    int i;
    depth = 0;
    len = $urandom_range(1, 14);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        add_char(8'($urandom_range(0, 255)));
      end else if (depth < 2 || (depth < STACK_DEPTH && $urandom_range(0, 1) == 1)) begin
        add_char(pick_digit());
        depth++;
      end else begin
        add_char(pick_op());
        depth--;
      end
    end
    // reduce to one value, sometimes leaving extra entries behind
    if ($urandom_range(0, 7) != 0) begin
      while (depth > 1) begin
        add_char(pick_op());
        depth--;
      end
    end
    end_expression();
  endfunction

  // fill the stack to or past its depth, then fold some of it back
  function automatic void add_overflow();
    int n;
    int i;
    n = $urandom_range(STACK_DEPTH, STACK_DEPTH + 2);
    for (i = 0; i < n; i++) add_char(pick_digit());
    n = $urandom_range(0, STACK_DEPTH - 1);
    for (i = 0; i < n; i++) add_char(pick_op());
    end_expression();
  endfunction

  // most negative value divided by minus one
  function automatic void add_min_over_minus_one();
    int i;
    add_text("10-");
    add_text("88*");
    for (i = 0; i < 8; i++) add_text("8*");
    add_text("2*");
    add_char($urandom_range(0, 1) ? CH_DIV : CH_REM);
    end_expression();
  endfunction

  function automatic void add_noise();
    int n;
    int i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)));
    end_expression();
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of requests with random gaps
  // ---------------------------------------------------------------------------
  char_req_t cur_req;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        evaluate_char(in_tdata, in_tlast);
        accepted_chars++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() == 0 || (pending_q[0].drain && result_q.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_req = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur_req.ch;
          in_tlast <= cur_req.last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = cyc[9] ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: report checks and receiver stalls
  // ---------------------------------------------------------------------------
  eval_result_t want;
  int           stall_left = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected report value %0d status %0d", $time,
                   $signed(out_tdata[31:0]), out_tdata[34:32]);
        end else begin
          want = result_q.pop_front();
          if (out_tdata[31:0] !== want.value) begin
            errors++;
            $display("%0t: value mismatch expected %0d actual %0d", $time,
                     $signed(want.value), $signed(out_tdata[31:0]));
          end
          if (out_tdata[34:32] !== want.status) begin
            errors++;
            $display("%0t: status mismatch expected %0d actual %0d", $time,
                     want.status, out_tdata[34:32]);
          end
        end
      end

      // one long hold so the block backs up into its input
      if (!hold_done && reports_seen == 8) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end

      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!cyc[8] && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  int random_chars;
  int drain_mark;
  int start_size;
  int pick;

  initial begin
    // bad characters at both ends of the byte range, top value kept
    add_char(8'h00);
    add_char(CH_NINE);
    add_char(8'hFF);
    end_expression();
    // all operators, negative truncation
    add_text("38%5*1-4+7/");
    end_expression();
    // divide by zero, then an underflow that must not replace it
    add_text("05/+");
    end_expression();
    // empty stack at report
    add_text("+");
    end_expression();
    // extra entries at report
    add_text("12");
    end_expression();
    add_text("0");
    end_expression();

    // random part, pausing for a full drain now and then
    random_chars = 0;
    drain_mark = 0;
    while (random_chars < RANDOM_CHARS) begin
      if (random_chars >= drain_mark) begin
        drain_next = 1'b1;
        drain_mark += 130;
      end
      start_size = pending_q.size();
      pick = $urandom_range(0, 99);
      if (random_chars == 0) add_min_over_minus_one();
      else if (pick < 72) add_well_formed();
      else if (pick < 80) add_overflow();
      else if (pick < 84) add_min_over_minus_one();
      else add_noise();
      random_chars += pending_q.size() - start_size;
    end
    total_chars = pending_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_chars < total_chars) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (result_q.size() != 0) begin
      errors++;
      $display("%0t: %0d reports never arrived", $time, result_q.size());
    end
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
